### rtl/lct_pkg.sv
package lct_pkg;

    // Field widths
    localparam int LBA_W  = 32;
    localparam int CYL_W  = 16;
    localparam int GEO_W  = 8;
    localparam int PROD_W = CYL_W + GEO_W;   // cylinder * heads + head
    localparam int CFG_W  = 16;              // widest geometry register
    localparam int CFG_IDX_W = 2;

    // Quotient bits retired per divider stage
    localparam int DIV_STEP = 4;

    // Geometry after reset
    localparam logic [GEO_W-1:0] HEADS_RST   = GEO_W'(2);
    localparam logic [GEO_W-1:0] SECTORS_RST = GEO_W'(18);
    localparam logic [CYL_W-1:0] CYLS_RST    = CYL_W'(80);

    // Request kinds
    localparam logic KIND_TO_CHS = 1'b0;
    localparam logic KIND_TO_LBA = 1'b1;

    // Geometry register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADS     = 2'd0,
        CFG_SECTORS   = 2'd1,
        CFG_CYLINDERS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             kind;
        logic [LBA_W-1:0] lba_in;
        logic [CYL_W-1:0] cylinder_in;
        logic [GEO_W-1:0] head_in;
        logic [GEO_W-1:0] sector_in;
    } t_req;

    typedef struct packed {
        logic [LBA_W-1:0] lba_out;
        logic [CYL_W-1:0] cylinder_out;
        logic [GEO_W-1:0] head_out;
        logic [GEO_W-1:0] sector_out;
        logic             fault;
    } t_rsp;

endpackage

### rtl/lba_chs_translator_top.sv
// LBA / CHS address translator.
// Request channel (i_req_valid / o_req_ready / i_req): kind 0 splits lba_in
// into cylinder, head and 1-based sector; kind 1 folds cylinder_in, head_in
// and sector_in back into an LBA. Every request gives exactly one response on
// the response channel (o_rsp_valid / i_rsp_ready / o_rsp), in request order.
// Geometry (heads, sectors per track, cylinders) is written through the
// i_cfg_* port; the user must write it only while no request is in flight,
// which the block itself does not enforce. Pipeline: input register, two
// multiply stages for kind 1, two 8-stage dividers retiring 4 quotient bits
// per stage, output register. Throughput: one request per cycle while the
// output register is not stalled.
// Stall: while the output register holds an untaken response, the whole
// pipeline freezes and o_req_ready is low; nothing is dropped or repeated.
// Reset: pipeline empties, geometry returns to 2 heads, 18 sectors per
// track, 80 cylinders.
module lba_chs_translator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  lct_pkg::t_req                 i_req,
    output logic                          o_rsp_valid,
    input  logic                          i_rsp_ready,
    output lct_pkg::t_rsp                 o_rsp,
    input  logic                          i_cfg_we,
    input  logic [lct_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [lct_pkg::CFG_W-1:0]     i_cfg_data
);
    import lct_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [LBA_W-1:0]  lba;
        logic [PROD_W-1:0] prod;
        logic [GEO_W-1:0]  sec_m1;
        logic              bad;
    } t_fold1;

    typedef struct packed {
        logic             kind;
        logic [LBA_W-1:0] lba;
        logic [LBA_W-1:0] lba_fold;
        logic             bad;
    } t_fold2;

    typedef struct packed {
        logic             kind;
        logic             bad;
        logic [LBA_W-1:0] lba_fold;
    } t_d1_side;

    typedef struct packed {
        logic             kind;
        logic             bad;
        logic [LBA_W-1:0] lba_fold;
        logic [GEO_W-1:0] rem1;
    } t_d2_side;

    localparam int D1_SIDE_W = $bits(t_d1_side);
    localparam int D2_SIDE_W = $bits(t_d2_side);

    // Geometry registers
    logic [GEO_W-1:0] r_heads;
    logic [GEO_W-1:0] r_sectors;
    logic [CYL_W-1:0] r_cyls;

    logic   adv;
    logic   r_s0_vld, r_s1_vld, r_s2_vld;
    t_req   r_s0_req;
    t_fold1 r_s1, n_s1;
    t_fold2 r_s2, n_s2;

    logic                  d1_vld;
    logic [LBA_W-1:0]      d1_quot;
    logic [GEO_W-1:0]      d1_rem;
    logic [D1_SIDE_W-1:0]  d1_side_in, d1_side_out;
    t_d1_side              d1_side;
    t_d2_side              d2_side;

    logic                  d2_vld;
    logic [LBA_W-1:0]      d2_quot;
    logic [GEO_W-1:0]      d2_rem;
    logic [D2_SIDE_W-1:0]  d2_side_in, d2_side_out;

    logic  r_rsp_valid;
    t_rsp  r_rsp, n_rsp;

    // Geometry write port; unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heads   <= HEADS_RST;
            r_sectors <= SECTORS_RST;
            r_cyls    <= CYLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_HEADS:     r_heads   <= i_cfg_data[GEO_W-1:0];
                CFG_SECTORS:   r_sectors <= i_cfg_data[GEO_W-1:0];
                CFG_CYLINDERS: r_cyls    <= i_cfg_data[CYL_W-1:0];
                default: ;
            endcase
        end
    end

    // Whole pipeline moves unless the output register is full and stalled
    assign adv         = !r_rsp_valid || i_rsp_ready;
    assign o_req_ready = adv;

    // Valid bits of the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s0_vld <= i_req_valid;
            r_s1_vld <= r_s0_vld;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Kind 1, first step: cylinder * heads + head, and the range check
    always_comb begin
        n_s1.kind   = r_s0_req.kind;
        n_s1.lba    = r_s0_req.lba_in;
        n_s1.prod   = PROD_W'(r_s0_req.cylinder_in) * PROD_W'(r_heads)
                    + PROD_W'(r_s0_req.head_in);
        n_s1.sec_m1 = r_s0_req.sector_in - GEO_W'(1);
        n_s1.bad    = (r_s0_req.head_in >= r_heads)
                   || (r_s0_req.sector_in == '0)
                   || (r_s0_req.sector_in > r_sectors);
    end

    // Kind 1, second step: times sectors plus sector - 1, modulo 2^32
    always_comb begin
        n_s2.kind     = r_s1.kind;
        n_s2.lba      = r_s1.lba;
        n_s2.lba_fold = LBA_W'(r_s1.prod) * LBA_W'(r_sectors) + LBA_W'(r_s1.sec_m1);
        n_s2.bad      = r_s1.bad;
    end

    // Front payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s0_req <= i_req;
            r_s1     <= n_s1;
            r_s2     <= n_s2;
        end
    end

    // lba / sectors
    always_comb begin
        d1_side.kind     = r_s2.kind;
        d1_side.bad      = r_s2.bad;
        d1_side.lba_fold = r_s2.lba_fold;
    end
    assign d1_side_in = d1_side;

    lct_divider #(
        .NUM_W  (LBA_W),
        .SIDE_W (D1_SIDE_W)
    ) u_div_sectors (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (r_s2_vld),
        .i_num   (r_s2.lba),
        .i_den   (r_sectors),
        .i_side  (d1_side_in),
        .o_valid (d1_vld),
        .o_quot  (d1_quot),
        .o_rem   (d1_rem),
        .o_side  (d1_side_out)
    );

    // (lba / sectors) / heads gives the cylinder, the remainder the head
    always_comb begin
        t_d1_side s;
        s                = t_d1_side'(d1_side_out);
        d2_side.kind     = s.kind;
        d2_side.bad      = s.bad;
        d2_side.lba_fold = s.lba_fold;
        d2_side.rem1     = d1_rem;
    end
    assign d2_side_in = d2_side;

    lct_divider #(
        .NUM_W  (LBA_W),
        .SIDE_W (D2_SIDE_W)
    ) u_div_heads (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_valid (d1_vld),
        .i_num   (d1_quot),
        .i_den   (r_heads),
        .i_side  (d2_side_in),
        .o_valid (d2_vld),
        .o_quot  (d2_quot),
        .o_rem   (d2_rem),
        .o_side  (d2_side_out)
    );

    // Response assembly and fault rules
    always_comb begin
        t_d2_side s;
        s     = t_d2_side'(d2_side_out);
        n_rsp = '0;
        if (s.kind == KIND_TO_CHS) begin
            if (r_heads == '0 || r_sectors == '0) begin
                n_rsp.fault = 1'b1;
            end else begin
                n_rsp.cylinder_out = d2_quot[CYL_W-1:0];
                n_rsp.head_out     = d2_rem;
                n_rsp.sector_out   = s.rem1 + GEO_W'(1);
                // full quotient against the cylinder count
                n_rsp.fault        = (d2_quot >= LBA_W'(r_cyls));
            end
        end else begin
            if (s.bad) begin
                n_rsp.lba_out = '1;
                n_rsp.fault   = 1'b1;
            end else begin
                n_rsp.lba_out = s.lba_fold;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (adv) begin
            r_rsp_valid <= d2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

### rtl/lct_divider.sv
// Pipelined restoring divider: NUM_W-bit numerator by an 8-bit divisor.
// Each stage retires DIV_STEP quotient bits; a side payload rides along.
module lct_divider #(
    parameter int NUM_W  = 32,
    parameter int SIDE_W = 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_adv,
    input  logic                     i_valid,
    input  logic [NUM_W-1:0]         i_num,
    input  logic [lct_pkg::GEO_W-1:0] i_den,
    input  logic [SIDE_W-1:0]        i_side,
    output logic                     o_valid,
    output logic [NUM_W-1:0]         o_quot,
    output logic [lct_pkg::GEO_W-1:0] o_rem,
    output logic [SIDE_W-1:0]        o_side
);
    import lct_pkg::*;

    localparam int STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W  = STAGES * DIV_STEP;

    // Stage registers: numerator shifts out at the top, quotient in at the bottom
    logic               r_vld  [STAGES];
    logic [PAD_W-1:0]   r_num  [STAGES];
    logic [GEO_W-1:0]   r_rem  [STAGES];
    logic [SIDE_W-1:0]  r_side [STAGES];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic              w_vld_in;
        logic [PAD_W-1:0]  w_num_in;
        logic [GEO_W-1:0]  w_rem_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [PAD_W-1:0]  n_num;
        logic [GEO_W-1:0]  n_rem;

        if (g == 0) begin : g_first
            assign w_vld_in  = i_valid;
            assign w_num_in  = PAD_W'(i_num);
            assign w_rem_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[g-1];
            assign w_num_in  = r_num[g-1];
            assign w_rem_in  = r_rem[g-1];
            assign w_side_in = r_side[g-1];
        end

        // DIV_STEP compare/subtract steps on the partial remainder
        always_comb begin : p_steps
            logic [GEO_W:0] trial;
            n_rem = w_rem_in;
            n_num = w_num_in;
            trial = '0;
            for (int k = 0; k < DIV_STEP; k++) begin
                trial = {n_rem, n_num[PAD_W-1]};
                if (trial >= {1'b0, i_den}) begin
                    n_rem = GEO_W'(trial - {1'b0, i_den});
                    n_num = {n_num[PAD_W-2:0], 1'b1};
                end else begin
                    n_rem = trial[GEO_W-1:0];
                    n_num = {n_num[PAD_W-2:0], 1'b0};
                end
            end
        end

        // Valid bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_adv) begin
                r_vld[g] <= w_vld_in;
            end
        end

        // Payload
        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_num[g]  <= n_num;
                r_rem[g]  <= n_rem;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_num[STAGES-1][NUM_W-1:0];
    assign o_rem   = r_rem[STAGES-1];
    assign o_side  = r_side[STAGES-1];

endmodule
